// ===== design/bit_vector_field_access_unit_assert.svh =====
// Assertion macros used by the bit-vector field access checker.
`ifndef BIT_VECTOR_FIELD_ACCESS_UNIT_ASSERT_SVH
`define BIT_VECTOR_FIELD_ACCESS_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BVFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvfa assertion failed");

// Next-cycle implication, checked out of reset.
`define BVFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvfa assertion failed");

`endif

// ===== design/bvfa_pkg.sv =====
// Types and constants of the bit-vector field access unit.
package bvfa_pkg;

    localparam int STORE_BYTES_DEF = 4096;
    localparam int LANES           = 8;
    localparam int ROWS_DEF        = (STORE_BYTES_DEF + LANES - 1) / LANES;
    localparam int ROW_W_DEF       = $clog2(ROWS_DEF);
    localparam int OFF_W           = 35;
    localparam int NEED_W          = 36;
    localparam int USED_W          = 13;

    localparam logic FN_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_NEG_WRITE = 2'd2,
        ST_NO_ROOM   = 2'd3
    } status_t;

    typedef enum logic {
        SQ_CLEAR,
        SQ_RUN
    } seq_state_t;

    typedef logic [7:0] lane_t;
    typedef lane_t [LANES-1:0] row_t;

    typedef struct packed {
        logic               func;
        logic signed [31:0] elem_offset;
        logic [6:0]         elem_bits;
        logic [63:0]        write_value;
    } in_t;

    typedef struct packed {
        logic [63:0]       read_value;
        status_t           status;
        logic [USED_W-1:0] used_length;
    } out_t;

    typedef struct packed {
        logic              do_read;
        logic              do_write;
        logic              sub;
        logic [2:0]        k;
        logic [2:0]        bit_off;
        logic [OFF_W-1:0]  byte_off;
        logic [NEED_W-1:0] need;
        status_t           status;
        logic [63:0]       wval;
    } dec_t;

endpackage

// ===== design/bvfa_mem.sv =====
// Eight byte-wide banks, one row per 8-byte-aligned group.
module bvfa_mem #(
    parameter int ROWS  = bvfa_pkg::ROWS_DEF,
    parameter int ROW_W = bvfa_pkg::ROW_W_DEF
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ROW_W-1:0]            rd_row,
    output bvfa_pkg::row_t              rd_data,
    input  logic                        wr_en,
    input  logic [ROW_W-1:0]            wr_row,
    input  logic [bvfa_pkg::LANES-1:0]  wr_lanes,
    input  bvfa_pkg::row_t              wr_data
);

    for (genvar b = 0; b < bvfa_pkg::LANES; b++) begin : g_bank
        logic [7:0] bank [ROWS];
        logic [7:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && wr_lanes[b])
            begin
                bank[wr_row] <= wr_data[b];
            end
            if (rd_en)
            begin
                q_reg <= bank[rd_row];
            end
        end

        assign rd_data[b] = q_reg;
    end

endmodule

// ===== design/bvfa_dec.sv =====
// Command decode: size check, byte/bit offset, end of element, status.
module bvfa_dec #(
    parameter int STORE_BYTES = bvfa_pkg::STORE_BYTES_DEF
) (
    input  bvfa_pkg::in_t  cmd,
    output bvfa_pkg::dec_t dec
);

    logic [31:0] raw;
    logic        neg;
    logic        legal;
    logic [2:0]  k;
    logic [3:0]  span;

    always_comb
    begin
        raw   = cmd.elem_offset;
        neg   = raw[31];
        legal = 1'b1;
        k     = 3'd0;
        unique case (cmd.elem_bits)
            7'd1:    k = 3'd0;
            7'd2:    k = 3'd1;
            7'd4:    k = 3'd2;
            7'd8:    k = 3'd3;
            7'd16:   k = 3'd4;
            7'd32:   k = 3'd5;
            7'd64:   k = 3'd6;
            default: legal = 1'b0;
        endcase

        dec.k    = k;
        dec.sub  = (k < 3'd3);
        dec.wval = cmd.write_value;
        if (k >= 3'd3)
        begin
            dec.byte_off = {3'b000, raw} << (k - 3'd3);
            dec.bit_off  = 3'd0;
            span         = 4'd1 << (k - 3'd3);
        end
        else
        begin
            dec.byte_off = {3'b000, raw >> (3'd3 - k)};
            dec.bit_off  = raw[2:0] << k;
            span         = 4'd1;
        end
        dec.need = {1'b0, dec.byte_off} + bvfa_pkg::NEED_W'(span);

        if (neg)
        begin
            dec.status = (cmd.func == bvfa_pkg::FN_WRITE) ? bvfa_pkg::ST_NEG_WRITE
                                                          : bvfa_pkg::ST_OK;
        end
        else if (!legal)
        begin
            dec.status = bvfa_pkg::ST_BAD_SIZE;
        end
        else if (cmd.func == bvfa_pkg::FN_WRITE &&
                 dec.need > bvfa_pkg::NEED_W'(STORE_BYTES))
        begin
            dec.status = bvfa_pkg::ST_NO_ROOM;
        end
        else
        begin
            dec.status = bvfa_pkg::ST_OK;
        end

        dec.do_read  = !neg && legal && (cmd.func != bvfa_pkg::FN_WRITE);
        dec.do_write = !neg && legal && (cmd.func == bvfa_pkg::FN_WRITE) &&
                       (dec.status == bvfa_pkg::ST_OK);
    end

endmodule

// ===== design/bit_vector_field_access_unit.sv =====
// Top level of the bit-vector field access unit.
// One command beat per cycle: start with busy low takes the command; its result
// passes through the stage-1 registers into rsp and shows there for exactly
// one cycle with done high. The receiver cannot stall; results must be taken
// as they come. The byte store sits in eight byte banks with a registered read;
// every element touches a single 8-byte row, read at accept and written back
// the next cycle, with the merged row forwarded to a back-to-back command on
// the same row. After reset, busy stays high while the ceil(STORE_BYTES/8)
// store rows (512 at the default size) are cleared one row per cycle.
module bit_vector_field_access_unit #(
    parameter int STORE_BYTES = bvfa_pkg::STORE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bvfa_pkg::in_t  cmd,
    output logic           done,
    output bvfa_pkg::out_t rsp
);

    localparam int LANES = bvfa_pkg::LANES;
    localparam int ROWS  = (STORE_BYTES + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LEN_W = $clog2(STORE_BYTES + 1);
    localparam int OFF_W = bvfa_pkg::OFF_W;

    function automatic logic [63:0] elem_mask(input logic [2:0] k);
        logic [63:0] m;
        if (k == 3'd6)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << (7'd1 << k)) - 64'd1;
        end
        return m;
    endfunction

    bvfa_pkg::seq_state_t state_reg, state_next;
    logic [ROW_W-1:0]     clr_row_reg, clr_row_next;

    logic                 accept;
    bvfa_pkg::dec_t       dec;
    bvfa_pkg::dec_t       s1_dec_reg;
    logic                 s1_valid_reg;
    logic                 fwd_hit_reg;
    bvfa_pkg::row_t       fwd_row_reg;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 done_reg;
    bvfa_pkg::out_t       rsp_reg, rsp_next;

    bvfa_pkg::row_t       rd_data;
    bvfa_pkg::row_t       old_row, vis_row, new_row;
    logic [LANES-1:0]     pipe_lanes;
    logic                 pipe_wr;
    logic                 mem_wr_en;
    logic [ROW_W-1:0]     mem_wr_row;
    logic [LANES-1:0]     mem_wr_lanes;
    bvfa_pkg::row_t       mem_wr_data;

    logic [2:0]           p;
    logic [3:0]           n_bytes;
    logic [3:0]           top_lane;
    logic [5:0]           sh;
    logic [63:0]          mask;
    logic [63:0]          row_be;
    logic [63:0]          wpos;
    logic [63:0]          rd_val;
    logic [7:0]           m8;
    logic [LEN_W+bvfa_pkg::USED_W-1:0] len_ext;

    // clear sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        busy         = 1'b0;
        unique case (state_reg)
            bvfa_pkg::SQ_CLEAR:
            begin
                busy         = 1'b1;
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = bvfa_pkg::SQ_RUN;
                end
            end
            bvfa_pkg::SQ_RUN:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;

    bvfa_dec #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dec (
        .cmd (cmd),
        .dec (dec)
    );

    // stage 1: extract and merge the row read at accept; drive the store write port
    always_comb
    begin
        p        = s1_dec_reg.byte_off[2:0];
        n_bytes  = s1_dec_reg.sub ? 4'd1 : (4'd1 << (s1_dec_reg.k - 3'd3));
        top_lane = 4'd8 - {1'b0, p} - n_bytes;
        sh       = {top_lane[2:0], 3'b000};
        mask     = elem_mask(s1_dec_reg.k);
        m8       = mask[7:0];
        old_row  = fwd_hit_reg ? fwd_row_reg : rd_data;

        for (int l = 0; l < LANES; l++)
        begin
            if ({s1_dec_reg.byte_off[OFF_W-1:3], 3'(l)} < OFF_W'(len_reg))
            begin
                vis_row[l] = old_row[l];
            end
            else
            begin
                vis_row[l] = 8'd0;
            end
            row_be[63-8*l -: 8] = vis_row[l];
        end

        if (!s1_dec_reg.do_read)
        begin
            rd_val = 64'd0;
        end
        else if (s1_dec_reg.sub)
        begin
            rd_val = ({56'd0, vis_row[p]} >> s1_dec_reg.bit_off) & mask;
        end
        else
        begin
            rd_val = (row_be >> sh) & mask;
        end

        wpos       = (s1_dec_reg.wval & mask) << sh;
        new_row    = old_row;
        pipe_lanes = '0;
        if (s1_dec_reg.sub)
        begin
            new_row[p] = (old_row[p] & ~(m8 << s1_dec_reg.bit_off)) |
                         ((s1_dec_reg.wval[7:0] & m8) << s1_dec_reg.bit_off);
            pipe_lanes[p] = 1'b1;
        end
        else
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (3'(l) >= p && 4'(l) < ({1'b0, p} + n_bytes))
                begin
                    new_row[l]    = wpos[63-8*l -: 8];
                    pipe_lanes[l] = 1'b1;
                end
            end
        end

        pipe_wr  = s1_valid_reg && s1_dec_reg.do_write;
        len_next = len_reg;
        if (pipe_wr && s1_dec_reg.need > bvfa_pkg::NEED_W'(len_reg))
        begin
            len_next = s1_dec_reg.need[LEN_W-1:0];
        end

        len_ext              = {{bvfa_pkg::USED_W{1'b0}}, len_next};
        rsp_next.read_value  = rd_val;
        rsp_next.status      = s1_dec_reg.status;
        rsp_next.used_length = len_ext[bvfa_pkg::USED_W-1:0];

        if (busy)
        begin
            mem_wr_en    = 1'b1;
            mem_wr_row   = clr_row_reg;
            mem_wr_lanes = '1;
            mem_wr_data  = '0;
        end
        else
        begin
            mem_wr_en    = pipe_wr;
            mem_wr_row   = s1_dec_reg.byte_off[ROW_W+2:3];
            mem_wr_lanes = pipe_lanes;
            mem_wr_data  = new_row;
        end
    end

    bvfa_mem #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_mem (
        .clk      (clk),
        .rd_en    (accept),
        .rd_row   (dec.byte_off[ROW_W+2:3]),
        .rd_data  (rd_data),
        .wr_en    (mem_wr_en),
        .wr_row   (mem_wr_row),
        .wr_lanes (mem_wr_lanes),
        .wr_data  (mem_wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bvfa_pkg::SQ_CLEAR;
            clr_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            len_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_row_reg  <= clr_row_next;
            s1_valid_reg <= accept;
            fwd_hit_reg  <= accept && pipe_wr &&
                            (s1_dec_reg.byte_off[OFF_W-1:3] == dec.byte_off[OFF_W-1:3]);
            len_reg      <= len_next;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dec_reg <= dec;
        end
        fwd_row_reg <= new_row;
        if (s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== design/bvfa_chk.sv =====
// Port-level checker for the bit-vector field access unit, bound to the top.
`include "bit_vector_field_access_unit_assert.svh"

module bvfa_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input bvfa_pkg::out_t rsp
);

    logic accepted;
    logic err_done;
    assign accepted = start && !busy;
    assign err_done = done && (rsp.status != bvfa_pkg::ST_OK);

    `BVFA_ASSERT_NEXT(a_result_two_later, accepted, ##1 done)
    `BVFA_ASSERT_NOW(a_no_spurious_result, done, $past(accepted, 2))
    `BVFA_ASSERT_NOW(a_error_reads_zero, err_done, rsp.read_value == 64'd0)
    `BVFA_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)

endmodule

bind bit_vector_field_access_unit bvfa_chk u_bvfa_chk (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the bit-vector field access unit: directed and random beats.
module testbench;
    import bvfa_pkg::*;

    localparam int          STORE_BYTES = STORE_BYTES_DEF;
    localparam logic        FN_READ     = 1'b0;
    localparam int          NUM_RANDOM  = 600;
    localparam int          QUIET_TAIL  = 100;
    localparam int          DRAIN       = 8;
    localparam int unsigned LIMIT       = 200000;

    class access_scoreboard;
        logic [7:0]      mem [STORE_BYTES];
        longint unsigned used;
        out_t            expected_results [$];
        int              errors;

        function new();
            foreach (mem[i])
            begin
                mem[i] = 8'h00;
            end
            used   = 0;
            errors = 0;
        endfunction

        function longint unsigned peek(longint unsigned addr);
            if (addr < used)
            begin
                return {56'd0, mem[addr]};
            end
            return 0;
        endfunction

        function bit size_ok(longint unsigned bits);
            return bits != 0 && bits <= 64 && (bits & (bits - 1)) == 0;
        endfunction

        // Works out the result of one accepted beat and updates the store image.
        function void note_command(in_t c);
            out_t            e;
            longint unsigned raw;
            longint unsigned bits;
            longint unsigned byte_at;
            longint unsigned bit_at;
            longint unsigned need;
            longint unsigned mask;
            longint unsigned b;
            longint unsigned n;
            longint unsigned i;
            e.read_value = '0;
            e.status     = ST_OK;
            raw  = {32'd0, c.elem_offset};
            bits = {57'd0, c.elem_bits};
            if (c.elem_offset[31])
            begin
                e.status = (c.func == FN_WRITE) ? ST_NEG_WRITE : ST_OK;
            end
            else if (!size_ok(bits))
            begin
                e.status = ST_BAD_SIZE;
            end
            else
            begin
                if (bits < 8)
                begin
                    bit_at  = (raw * bits) & 7;
                    byte_at = raw / (8 / bits);
                    n       = 1;
                end
                else
                begin
                    bit_at  = 0;
                    byte_at = raw * (bits / 8);
                    n       = bits / 8;
                end
                need = byte_at + (bit_at + bits + 7) / 8;
                if (c.func != FN_WRITE)
                begin
                    if (bits < 8)
                    begin
                        e.read_value = (peek(byte_at) >> bit_at) & ((64'd1 << bits) - 1);
                    end
                    else
                    begin
                        b = 0;
                        for (i = 0; i < n; i++)
                        begin
                            b = (b << 8) | peek(byte_at + i);
                        end
                        e.read_value = b;
                    end
                end
                else if (need > STORE_BYTES)
                begin
                    e.status = ST_NO_ROOM;
                end
                else
                begin
                    if (need > used)
                    begin
                        used = need;
                    end
                    if (bits < 8)
                    begin
                        mask = (64'd1 << bits) - 1;
                        b = {56'd0, mem[byte_at]};
                        b &= ~(mask << bit_at);
                        b |= (c.write_value & mask) << bit_at;
                        mem[byte_at] = b[7:0];
                    end
                    else
                    begin
                        for (i = 0; i < n; i++)
                        begin
                            b = c.write_value >> (8 * (n - 1 - i));
                            mem[byte_at + i] = b[7:0];
                        end
                    end
                end
            end
            e.used_length = used[USED_W-1:0];
            expected_results.push_back(e);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_result(out_t r);
            out_t e;
            if (expected_results.size() == 0)
            begin
                report("unexpected beat, read_value", r.read_value, 64'd0);
            end
            else
            begin
                e = expected_results.pop_front();
                if (r.read_value !== e.read_value)
                begin
                    report("read_value", r.read_value, e.read_value);
                end
                if (r.status !== e.status)
                begin
                    report("status", {62'd0, r.status}, {62'd0, e.status});
                end
                if (r.used_length !== e.used_length)
                begin
                    report("used_length", {51'd0, r.used_length}, {51'd0, e.used_length});
                end
            end
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    in_t   cmd;
    logic  done;
    out_t  rsp;

    access_scoreboard sb;
    int unsigned      cycles;
    int               beat_count;

    bit_vector_field_access_unit #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(rsp);
        end
    end

    function in_t make_cmd(logic f, logic [31:0] off, logic [6:0] bits, logic [63:0] wv);
        in_t c;
        c.func        = f;
        c.elem_offset = off;
        c.elem_bits   = bits;
        c.write_value = wv;
        return c;
    endfunction

    function bit legal_bits(logic [6:0] bits);
        return bits != 0 && bits <= 64 && (bits & (bits - 1)) == 0;
    endfunction

    // Mostly well-formed accesses inside a window that grows with the run,
    // plus accesses near the end of the store, negative and wild offsets.
    function in_t random_cmd(int idx);
        logic [6:0]  bits;
        logic [31:0] off;
        int unsigned addr;
        int unsigned window;
        int unsigned pick;
        if ($urandom_range(0, 99) < 85)
        begin
            bits = 7'd1 << $urandom_range(0, 6);
        end
        else
        begin
            do
            begin
                bits = 7'($urandom_range(0, 127));
            end
            while (legal_bits(bits));
        end
        window = 32 + idx * 8;
        if (window > STORE_BYTES)
        begin
            window = STORE_BYTES;
        end
        addr = $urandom_range(0, window - 1);
        pick = $urandom_range(0, 99);
        if (pick >= 70 && pick < 80 && idx > NUM_RANDOM / 2)
        begin
            addr = $urandom_range(STORE_BYTES - 16, STORE_BYTES + 15);
        end
        if (!legal_bits(bits))
        begin
            off = addr;
        end
        else if (bits >= 8)
        begin
            off = addr / (bits / 8);
        end
        else
        begin
            off = addr * (8 / bits) + $urandom_range(0, 8 / bits - 1);
        end
        if (pick >= 80 && pick < 90)
        begin
            off = $urandom | 32'h8000_0000;
        end
        else if (pick >= 90)
        begin
            off = $urandom;
        end
        return make_cmd(1'($urandom_range(0, 1)), off, bits, {$urandom, $urandom});
    endfunction

    task idle_gap();
        if (beat_count < NUM_RANDOM - QUIET_TAIL && (beat_count / 40) % 3 != 2
            && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task send(in_t c);
        idle_gap();
        start <= 1'b1;
        cmd   <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_command(c);
        beat_count++;
    endtask

    initial
    begin
        sb = new();
        cycles     = 0;
        beat_count = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(make_cmd(FN_READ,  32'd0, 7'd8, 64'd0));
        send(make_cmd(FN_WRITE, 32'd0, 7'd64, 64'h0123_4567_89ab_cdef));
        send(make_cmd(FN_READ,  32'd0, 7'd8, 64'd0));
        send(make_cmd(FN_READ,  32'd0, 7'd1, 64'd0));
        send(make_cmd(FN_READ,  32'd3, 7'd4, 64'd0));
        send(make_cmd(FN_READ,  32'd6, 7'd2, 64'd0));
        send(make_cmd(FN_WRITE, 32'd127, 7'd1, '1));
        send(make_cmd(FN_WRITE, 32'd33, 7'd2, 64'd3));
        send(make_cmd(FN_WRITE, 32'd35, 7'd4, 64'hffff_ffff_ffff_fffa));
        send(make_cmd(FN_READ,  32'd8, 7'd16, 64'd0));
        // element straddling the current length
        send(make_cmd(FN_READ,  32'd4, 7'd32, 64'd0));
        send(make_cmd(FN_READ,  32'd2, 7'd64, 64'd0));
        send(make_cmd(FN_READ,  32'h8000_0000, 7'd8, 64'd0));
        send(make_cmd(FN_WRITE, 32'hffff_ffff, 7'd64, '1));
        send(make_cmd(FN_WRITE, 32'h8000_0000, 7'd3, '1));
        send(make_cmd(FN_READ,  32'd0, 7'd0, 64'd0));
        send(make_cmd(FN_WRITE, 32'd1, 7'd127, '1));
        send(make_cmd(FN_READ,  32'd0, 7'd65, 64'd0));
        send(make_cmd(FN_WRITE, 32'd0, 7'd3, '1));
        send(make_cmd(FN_WRITE, STORE_BYTES / 8, 7'd64, '1));
        send(make_cmd(FN_WRITE, STORE_BYTES * 8, 7'd1, '1));
        send(make_cmd(FN_WRITE, 32'h7fff_ffff, 7'd32, '1));
        send(make_cmd(FN_READ,  32'h7fff_ffff, 7'd64, 64'd0));
        send(make_cmd(FN_WRITE, 32'd0, 7'd64, '1));
        send(make_cmd(FN_READ,  32'd0, 7'd64, 64'd0));

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            send(random_cmd(i));
        end
        start <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
